// ----- design/shortest_path_dense_graph_defines.svh -----
// Assertion macros for the shortest path engine (clock clk, reset rst).
`ifndef SHORTEST_PATH_DENSE_GRAPH_DEFINES_SVH
`define SHORTEST_PATH_DENSE_GRAPH_DEFINES_SVH

// Same-cycle implication, off during reset
`define SPDG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define SPDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/spdg_pkg.sv -----
// Shared constants for the shortest path engine.
`timescale 1ns / 1ps
`default_nettype none

package spdg_pkg;

  // Distance word and its special codes
  localparam int DIST_BITS = 21;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_SAT = DIST_INF - DIST_BITS'(1);

  // Width used to range-check vertex numbers against the vertex count
  localparam int VCMP_BITS = 9;

  // Item codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- design/spdg_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/shortest_path_dense_graph.sv -----
// Shortest path engine over a dense directed graph held in RAM.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   item in  | start, busy (out)     | action, row_vertex, col_vertex,
//            |                       | edge_weight, source_vertex, dest_vertex
//   result   | done (one-cycle pulse)| path_distance, reachable
//
// An item transfers at a clock edge with start high and busy low.
// A matrix write completes at its transfer edge; busy stays low.
// A query runs Dijkstra over the weight RAM: it loads the distance RAM, then makes
// up to N-1 passes of a minimum scan and a row relax, each limited to one distance
// RAM read per cycle, then reads out the result. Out-of-range queries answer at once.
// After reset the weight RAM is swept to zero with busy high.
// done is held for exactly one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "shortest_path_dense_graph_defines.svh"

module shortest_path_dense_graph
  import spdg_pkg::*;
#(
  parameter int NUM_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action,
  input  logic [4:0]           row_vertex,
  input  logic [4:0]           col_vertex,
  input  logic [15:0]          edge_weight,
  input  logic [4:0]           source_vertex,
  input  logic [4:0]           dest_vertex,
  output logic                 done,
  output logic [DIST_BITS-1:0] path_distance,
  output logic                 reachable
);

  localparam int VW     = $clog2(NUM_VERTICES);
  localparam int CW     = VW + 1;
  localparam int MDEPTH = NUM_VERTICES * NUM_VERTICES;
  localparam int AW     = $clog2(MDEPTH);
  localparam int SW     = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INIT, S_PICK, S_RELAX, S_READ, S_ANSWER
  } state_t;

  state_t                  state;
  logic [AW-1:0]           clr_addr;
  logic [CW-1:0]           cnt;
  logic [VW-1:0]           pass;
  logic [VW-1:0]           src;
  logic [VW-1:0]           dst;
  logic [AW-1:0]           row_base;
  logic [DIST_BITS-1:0]    best;
  logic [DIST_BITS-1:0]    du;
  logic [VW-1:0]           pick;
  logic [NUM_VERTICES-1:0] fin;

  // RAM ports
  logic                   wram_we;
  logic [AW-1:0]          wram_waddr;
  logic [WEIGHT_BITS-1:0] wram_wdata;
  logic [AW-1:0]          wram_raddr;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic                   dram_we;
  logic [VW-1:0]          dram_waddr;
  logic [DIST_BITS-1:0]   dram_wdata;
  logic [VW-1:0]          dram_raddr;
  logic [DIST_BITS-1:0]   dist_rd;

  logic                 accept;
  logic                 row_ok, col_ok, src_ok, dst_ok;
  logic                 wr_item;
  logic [AW-1:0]        wr_addr;
  logic [VW-1:0]        scan_idx;
  logic [VW-1:0]        proc_idx;
  logic                 cnt_last;
  logic                 cand;
  logic [DIST_BITS-1:0] best_next;
  logic [VW-1:0]        pick_next;
  logic [SW-1:0]        sum;
  logic [DIST_BITS-1:0] sum_sat;
  logic                 upd;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Input range checks and matrix write address
  assign row_ok  = VCMP_BITS'(row_vertex) < VCMP_BITS'(NUM_VERTICES);
  assign col_ok  = VCMP_BITS'(col_vertex) < VCMP_BITS'(NUM_VERTICES);
  assign src_ok  = VCMP_BITS'(source_vertex) < VCMP_BITS'(NUM_VERTICES);
  assign dst_ok  = VCMP_BITS'(dest_vertex) < VCMP_BITS'(NUM_VERTICES);
  assign wr_item = accept && (action == ACT_WRITE) && row_ok && col_ok;
  assign wr_addr = AW'(AW'(row_vertex) * AW'(NUM_VERTICES) + AW'(col_vertex));

  // Scan counter: issue read at cnt, process returned data for cnt-1
  assign scan_idx = cnt[VW-1:0];
  assign proc_idx = VW'(cnt - CW'(1));
  assign cnt_last = (cnt == CW'(NUM_VERTICES));

  // Minimum search; ties go to the later vertex
  assign cand      = !fin[proc_idx] && (dist_rd <= best);
  assign best_next = cand ? dist_rd : best;
  assign pick_next = cand ? proc_idx : pick;

  // Relaxation with saturation below the unreachable code
  assign sum     = SW'(du) + SW'(w_rd);
  assign sum_sat = (sum > SW'(DIST_SAT)) ? DIST_SAT : sum[DIST_BITS-1:0];
  assign upd     = !fin[proc_idx] && (w_rd != '0) && (sum_sat < dist_rd);

  // Weight RAM port control
  always_comb begin
    wram_we    = 1'b0;
    wram_waddr = wr_addr;
    wram_wdata = WEIGHT_BITS'(edge_weight);
    if (state == S_CLEAR) begin
      wram_we    = 1'b1;
      wram_waddr = clr_addr;
      wram_wdata = '0;
    end else if (wr_item) begin
      wram_we = 1'b1;
    end
  end

  assign wram_raddr = AW'(row_base + AW'(scan_idx));

  // Distance RAM port control
  always_comb begin
    dram_we    = 1'b0;
    dram_waddr = proc_idx;
    dram_wdata = sum_sat;
    if (state == S_INIT) begin
      dram_we    = 1'b1;
      dram_waddr = scan_idx;
      dram_wdata = (scan_idx == src) ? '0 : DIST_INF;
    end else if (state == S_RELAX) begin
      dram_we = (cnt != '0) && upd;
    end
  end

  assign dram_raddr = (state == S_READ) ? dst : scan_idx;

  spdg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .raddr (wram_raddr),
    .rdata (w_rd)
  );

  spdg_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (NUM_VERTICES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (dram_raddr),
    .rdata (dist_rd)
  );

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      pass     <= '0;
      fin      <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (action == ACT_QUERY)) begin
            if (src_ok && dst_ok) begin
              src   <= VW'(source_vertex);
              dst   <= VW'(dest_vertex);
              fin   <= '0;
              cnt   <= '0;
              pass  <= '0;
              state <= S_INIT;
            end else begin
              done          <= 1'b1;
              path_distance <= DIST_INF;
              reachable     <= 1'b0;
            end
          end
        end
        S_INIT: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NUM_VERTICES - 1)) begin
            cnt   <= '0;
            best  <= DIST_INF;
            pick  <= '0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          cnt <= cnt + CW'(1);
          if (cnt != '0) begin
            best <= best_next;
            pick <= pick_next;
          end
          if (cnt_last) begin
            cnt             <= '0;
            fin[pick_next]  <= 1'b1;
            du              <= best_next;
            row_base        <= AW'(AW'(pick_next) * AW'(NUM_VERTICES));
            // nothing left reachable: no distance can change any more
            state <= (best_next == DIST_INF) ? S_READ : S_RELAX;
          end
        end
        S_RELAX: begin
          cnt <= cnt + CW'(1);
          if (cnt_last) begin
            cnt <= '0;
            if (pass == VW'(NUM_VERTICES - 2)) begin
              state <= S_READ;
            end else begin
              pass  <= pass + VW'(1);
              best  <= DIST_INF;
              pick  <= '0;
              state <= S_PICK;
            end
          end
        end
        S_READ: begin
          state <= S_ANSWER;
        end
        S_ANSWER: begin
          done          <= 1'b1;
          path_distance <= dist_rd;
          reachable     <= (dist_rd != DIST_INF);
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `SPDG_ASSERT_IMPL(a_done_not_busy, done, !busy, "result strobe while busy")
  `SPDG_ASSERT_NEXT(a_write_one_cycle, start && !busy && action == ACT_WRITE, !busy && !done, "matrix write did not complete in one cycle")
  `SPDG_ASSERT_IMPL(a_reach_flag, done, reachable == (path_distance != DIST_INF), "reachable flag disagrees with distance")
  `SPDG_ASSERT_NEXT(a_relax_marked, state == S_PICK && cnt_last && best_next != DIST_INF, state == S_RELAX && fin != '0, "relax pass entered without a finished vertex")

endmodule

`default_nettype wire

// ----- sim/spdg_path_checker.sv -----
// Path checker: predicts each query answer of the shortest path engine and compares.
`timescale 1ns / 1ps

module spdg_path_checker
  import spdg_pkg::*;
#(
  parameter int NUM_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 action,
  input  logic [4:0]           row_vertex,
  input  logic [4:0]           col_vertex,
  input  logic [15:0]          edge_weight,
  input  logic [4:0]           source_vertex,
  input  logic [4:0]           dest_vertex,
  input  logic                 done,
  input  logic [DIST_BITS-1:0] path_distance,
  input  logic                 reachable,
  output int                   fail_count,
  output int                   outstanding,
  output int                   write_total,
  output int                   query_total,
  output int                   reach_total
);

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 reach;
  } path_answer_t;

  // Shadow copy of the weight RAM, zero means no edge
  logic [WEIGHT_BITS-1:0] edge_table [NUM_VERTICES][NUM_VERTICES];
  // Answers of accepted queries, oldest first
  path_answer_t           path_answers [$];

  // Dijkstra over the shadow matrix; ties go to the highest vertex
  function automatic logic [DIST_BITS-1:0] shortest_distance(input int src, input int dst);
    logic [DIST_BITS-1:0]             cost [NUM_VERTICES];
    logic                             settled [NUM_VERTICES];
    logic [DIST_BITS-1:0]             best;
    logic [DIST_BITS-1:0]             du;
    logic [DIST_BITS+WEIGHT_BITS-1:0] sum;
    int                               u;
    int                               v;
    int                               sweep;
    if (src >= NUM_VERTICES || dst >= NUM_VERTICES) return DIST_INF;
    for (v = 0; v < NUM_VERTICES; v++) begin
      cost[v]    = DIST_INF;
      settled[v] = 1'b0;
    end
    cost[src] = '0;
    for (sweep = 0; sweep < NUM_VERTICES - 1; sweep++) begin
      best = DIST_INF;
      u    = 0;
      for (v = 0; v < NUM_VERTICES; v++) begin
        if (!settled[v] && cost[v] <= best) begin
          best = cost[v];
          u    = v;
        end
      end
      settled[u] = 1'b1;
      du         = cost[u];
      if (du != DIST_INF) begin
        for (v = 0; v < NUM_VERTICES; v++) begin
          if (!settled[v] && edge_table[u][v] != '0) begin
            sum = du + edge_table[u][v];
            // long sums stop one short of the unreachable code
            if (sum > DIST_SAT) sum = DIST_SAT;
            if (sum < cost[v]) cost[v] = sum[DIST_BITS-1:0];
          end
        end
      end
    end
    return cost[dst];
  endfunction

  always @(posedge clk) begin : compare
    path_answer_t want;
    int           r;
    int           c;
    if (rst) begin
      for (r = 0; r < NUM_VERTICES; r++) begin
        for (c = 0; c < NUM_VERTICES; c++) edge_table[r][c] = '0;
      end
      path_answers.delete();
      fail_count  = 0;
      write_total = 0;
      query_total = 0;
      reach_total = 0;
      outstanding <= 0;
    end else begin
      // Item transfer: update the matrix or queue the predicted answer
      if (start && !busy) begin
        if (action == ACT_WRITE) begin
          if (row_vertex < NUM_VERTICES && col_vertex < NUM_VERTICES)
            edge_table[row_vertex][col_vertex] = WEIGHT_BITS'(edge_weight);
          write_total++;
        end else begin
          want.distance = shortest_distance(source_vertex, dest_vertex);
          want.reach    = (want.distance != DIST_INF);
          path_answers.push_back(want);
          query_total++;
        end
      end
      // Result strobe: compare against the oldest queued answer
      if (done) begin
        if (path_answers.size() == 0) begin
          $display("%0t: result with no query waiting: path_distance %0d reachable %0d",
                   $time, path_distance, reachable);
          fail_count++;
        end else begin
          want = path_answers.pop_front();
          if (want.reach) reach_total++;
          if (path_distance !== want.distance) begin
            $display("%0t: path_distance expected %0d actual %0d",
                     $time, want.distance, path_distance);
            fail_count++;
          end
          if (reachable !== want.reach) begin
            $display("%0t: reachable expected %0b actual %0b", $time, want.reach, reachable);
            fail_count++;
          end
        end
      end
      outstanding <= path_answers.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the shortest path engine: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import spdg_pkg::*;

  localparam int VERTEX_COUNT   = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2200;
  localparam int RANDOM_ITEMS   = 560;
  localparam int PHASE_COUNT    = 3;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 action;
  logic [4:0]           row_vertex;
  logic [4:0]           col_vertex;
  logic [15:0]          edge_weight;
  logic [4:0]           source_vertex;
  logic [4:0]           dest_vertex;
  logic                 done;
  logic [DIST_BITS-1:0] path_distance;
  logic                 reachable;

  int fail_count;
  int outstanding;
  int write_total;
  int query_total;
  int reach_total;
  int idle_pct;
  int sent_items;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  shortest_path_dense_graph #(
    .NUM_VERTICES(VERTEX_COUNT)
  ) i_dut (.*);

  spdg_path_checker #(
    .NUM_VERTICES(VERTEX_COUNT)
  ) i_checker (.*);

  // Watchdog: cycles with neither an item transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
      $display("shortest_path_dense_graph regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle cycle with start low and noise on the payload
  task automatic idle_cycle();
    start         <= 1'b0;
    action        <= 1'($urandom);
    row_vertex    <= 5'($urandom);
    col_vertex    <= 5'($urandom);
    edge_weight   <= 16'($urandom);
    source_vertex <= 5'($urandom);
    dest_vertex   <= 5'($urandom);
    @(posedge clk);
  endtask

  // Present one item and hold it until the transfer
  task automatic send_item(input logic act, input logic [4:0] row, input logic [4:0] col,
                           input logic [15:0] weight, input logic [4:0] src,
                           input logic [4:0] dst);
    // rare long pause so start rises at any point of a running query
    if (idle_pct != 0 && $urandom_range(99) < 2)
      repeat ($urandom_range(1, 2500)) idle_cycle();
    while ($urandom_range(99) < idle_pct) idle_cycle();
    start         <= 1'b1;
    action        <= act;
    row_vertex    <= row;
    col_vertex    <= col;
    edge_weight   <= weight;
    source_vertex <= src;
    dest_vertex   <= dst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_edge(input logic [4:0] row, input logic [4:0] col,
                            input logic [15:0] weight);
    send_item(ACT_WRITE, row, col, weight, 5'($urandom), 5'($urandom));
  endtask

  task automatic ask_path(input logic [4:0] src, input logic [4:0] dst);
    send_item(ACT_QUERY, 5'($urandom), 5'($urandom), 16'($urandom), src, dst);
  endtask

  // Hold off until every queued answer has come back
  task automatic drain_answers();
    idle_cycle();
    while (outstanding != 0) idle_cycle();
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(7))
      0, 1:    return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(65280, 65535));
      4, 5:    return 16'($urandom_range(1, 15));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // One random sequence: graph edits then queries, chains, cut rows, or noise
  task automatic random_episode();
    int         kind;
    int         n;
    logic [4:0] head;
    logic [4:0] tail;
    logic [4:0] hop;
    kind = $urandom_range(19);
    if (kind < 12) begin
      n = $urandom_range(4, 10);
      repeat (n) write_edge(5'($urandom), 5'($urandom), pick_weight());
      n = $urandom_range(1, 3);
      repeat (n) begin
        head = 5'($urandom);
        ask_path(head, ($urandom_range(9) == 0) ? head : 5'($urandom));
      end
    end else if (kind < 16) begin
      // chain of heavy edges for long distances
      head = 5'($urandom);
      tail = head;
      n    = $urandom_range(3, 8);
      repeat (n) begin
        hop = 5'($urandom);
        write_edge(tail, hop, 16'($urandom_range(50000, 65535)));
        tail = hop;
      end
      ask_path(head, tail);
      ask_path(tail, head);
    end else if (kind == 16) begin
      // clear a whole row so the vertex cannot leave
      head = 5'($urandom);
      for (int c = 0; c < VERTEX_COUNT; c++) write_edge(head, 5'(c), 16'd0);
      ask_path(head, 5'($urandom));
      ask_path(5'($urandom), head);
    end else begin
      n = $urandom_range(3, 6);
      repeat (n)
        send_item(1'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                  5'($urandom), 5'($urandom));
    end
  endtask

  initial begin : stimulus
    int idle_plan [PHASE_COUNT];
    int goal;
    idle_plan     = '{0, 49, 8};
    rst           = 1'b1;
    start         = 1'b0;
    action        = ACT_WRITE;
    row_vertex    = '0;
    col_vertex    = '0;
    edge_weight   = '0;
    source_vertex = '0;
    dest_vertex   = '0;
    idle_pct      = 0;
    sent_items    = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, self query, extremes, removal, equal-cost paths
    ask_path(5'd0, 5'd31);
    ask_path(5'd7, 5'd7);
    write_edge(5'd0, 5'd31, 16'hFFFF);
    ask_path(5'd0, 5'd31);
    ask_path(5'd31, 5'd0);
    write_edge(5'd0, 5'd1, 16'd1);
    write_edge(5'd1, 5'd31, 16'd1);
    ask_path(5'd0, 5'd31);
    write_edge(5'd31, 5'd31, 16'd5);
    ask_path(5'd31, 5'd31);
    write_edge(5'd0, 5'd31, 16'd0);
    ask_path(5'd0, 5'd31);
    write_edge(5'd1, 5'd31, 16'd0);
    ask_path(5'd0, 5'd31);
    write_edge(5'd0, 5'd2, 16'd3);
    write_edge(5'd2, 5'd31, 16'd3);
    write_edge(5'd0, 5'd3, 16'd2);
    write_edge(5'd3, 5'd31, 16'd4);
    ask_path(5'd0, 5'd31);
    write_edge(5'd31, 5'd0, 16'h5555);
    ask_path(5'd31, 5'd0);
    ask_path(5'd31, 5'd2);
    drain_answers();

    // Random part in sender gap phases
    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_pct = idle_plan[p];
      goal     = sent_items + RANDOM_ITEMS / PHASE_COUNT;
      while (sent_items < goal) random_episode();
      drain_answers();
    end

    // Let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) idle_cycle();
    $display("Covered %0d edge writes and %0d path queries (%0d reachable, %0d unreachable)",
             write_total, query_total, reach_total, query_total - reach_total);
    $display("Sender gaps of none, 49 and 8 percent, with long pauses across running queries");
    if (fail_count == 0) begin
      $display("shortest_path_dense_graph regression: pass");
    end else begin
      $display("shortest_path_dense_graph regression: fail");
    end
    $finish;
  end

endmodule
